/* hdl/multichannel_timed_strobe_pwm_defines.svh */
// ----------------------------------------------------------------------------
// Timed strobe PWM assertion macros
// Concurrent check wrappers used by the top RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_TIMED_STROBE_PWM_DEFINES_SVH
`define MULTICHANNEL_TIMED_STROBE_PWM_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MTSPWM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MTSPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mtspwm_pkg.sv */
// ----------------------------------------------------------------------------
// Timed strobe PWM package
// Field widths, codes and channel record types for the strobe block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtspwm_pkg;

  localparam int CHANNELS_DEF = 4;

  localparam int MODE_W  = 2;
  localparam int CHF_W   = 2;
  localparam int DUR_W   = 16;
  localparam int PER_W   = 16;
  localparam int DUTY_W  = 8;
  localparam int PH_W    = 16;
  localparam int EV_W    = 2;
  localparam int PROD_W  = PER_W + DUTY_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int PCT     = 100;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_SETUP = 2'd1;
  localparam mode_t MODE_QUERY = 2'd2;

  typedef logic [EV_W-1:0] ev_code_t;
  localparam ev_code_t EV_TOGGLE   = 2'd0;
  localparam ev_code_t EV_COMPLETE = 2'd1;
  localparam ev_code_t EV_QUERY    = 2'd2;

  typedef struct packed {
    logic [DUR_W-1:0]  rem;
    logic [PER_W-1:0]  period;
    logic [DUTY_W-1:0] duty;
    logic [PH_W-1:0]   phase;
  } chan_t;

  typedef struct packed {
    chan_t    wb;
    logic     evt;
    ev_code_t code;
  } unit_out_t;

endpackage

`default_nettype wire

/* hdl/mtspwm_ifs.sv */
// ----------------------------------------------------------------------------
// Timed strobe PWM channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtspwm_item_if import mtspwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHF_W-1:0]  channel;
  logic [DUR_W-1:0]  duration;
  logic [PER_W-1:0]  period;
  logic [DUTY_W-1:0] duty;

  modport source (output valid, mode, channel, duration, period, duty, input ready);
  modport sink (input valid, mode, channel, duration, period, duty, output ready);
endinterface

interface mtspwm_result_if import mtspwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CHF_W-1:0] channel_res;
  logic [EV_W-1:0]  event_res;
  logic             active;
  logic             last;

  modport source (output valid, channel_res, event_res, active, last, input ready);
  modport sink (input valid, channel_res, event_res, active, last, output ready);
endinterface

`default_nettype wire

/* hdl/mtspwm_bank.sv */
// ----------------------------------------------------------------------------
// Timed strobe PWM channel bank
// Per-channel duration, period, duty and phase, one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mtspwm_bank import mtspwm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CH_W-1:0] rd_addr,
  output chan_t           rd,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  chan_t           wr
);

  chan_t entry [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        entry[i] <= '0;
      end
    end else if (wr_en) begin
      entry[wr_addr] <= wr;
    end
  end

  assign rd = entry[rd_addr];

endmodule

`default_nettype wire

/* hdl/mtspwm_unit.sv */
// ----------------------------------------------------------------------------
// Timed strobe PWM channel update unit
// Shared two-step datapath: duty product and phase step, then pulse compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mtspwm_unit import mtspwm_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  chan_t     cur,
  output unit_out_t res
);

  chan_t              cur_q;
  logic [PROD_W-1:0]  prod;
  logic [PH_W-1:0]    ph_inc;
  logic [DUR_W-1:0]   rem_dec;
  logic [PH_W-1:0]    ph_sum;
  logic [DIFF_W-1:0]  pct_ph;
  logic [DIFF_W-1:0]  diff;
  logic               hit;
  logic               rem_nz;

  assign ph_sum = cur.phase + PH_W'(1);

  always_ff @(posedge clk) begin
    if (load) begin
      cur_q   <= cur;
      prod    <= PROD_W'(cur.period) * PROD_W'(cur.duty);
      ph_inc  <= (ph_sum == cur.period) ? '0 : ph_sum;
      rem_dec <= cur.rem - DUR_W'(1);
    end
  end

  // phase times one hundred as 64 + 32 + 4
  assign pct_ph = (DIFF_W'(ph_inc) << 6) + (DIFF_W'(ph_inc) << 5) + (DIFF_W'(ph_inc) << 2);
  assign diff   = DIFF_W'(prod) - pct_ph;
  assign hit    = (ph_inc == '0) || (!diff[DIFF_W-1] && (diff < DIFF_W'(PCT)));
  assign rem_nz = (cur_q.rem != '0);

  always_comb begin
    res      = '0;
    res.wb   = cur_q;
    res.code = EV_TOGGLE;
    if (rem_nz && (rem_dec == '0)) begin
      res.wb.rem    = '0;
      res.wb.period = '0;
      res.wb.phase  = '0;
      res.evt       = 1'b1;
      res.code      = EV_COMPLETE;
    end else begin
      if (rem_nz) begin
        res.wb.rem = rem_dec;
      end
      if (cur_q.period != '0) begin
        res.wb.phase = ph_inc;
        res.evt      = hit;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/multichannel_timed_strobe_pwm.sv */
// ----------------------------------------------------------------------------
// Multichannel timed strobe PWM
// Setup: written to the channel bank on acceptance, no result. Query: the channel
// is read in ST_QUERY and the answer is registered out from ST_FLUSH.
// Tick: each channel goes through ST_LOAD and ST_CHECK in the shared update unit,
// each event through ST_PUSH, and ST_FLUSH releases the final result.
// A new item is taken only in idle; output stalls can hold ST_PUSH and ST_FLUSH.
// Synchronous reset clears every channel to inactive and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multichannel_timed_strobe_pwm_defines.svh"

module multichannel_timed_strobe_pwm import mtspwm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mtspwm_item_if.sink       item,
  mtspwm_result_if.source   result
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_QUERY = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_PUSH  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t           state;
  logic [CH_W-1:0]  idx;
  logic [CHF_W-1:0] ch_q;
  ev_code_t         ev_code;

  logic             held_valid;
  logic [CHF_W-1:0] held_ch;
  ev_code_t         held_code;
  logic             held_active;

  logic             out_valid;
  logic [CHF_W-1:0] out_ch;
  ev_code_t         out_code;
  logic             out_active;
  logic             out_last;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             last_idx;
  logic             setup_ok;
  logic             query_ok;

  logic [CH_W-1:0]  rd_addr;
  chan_t            rd;
  logic             wr_en;
  logic [CH_W-1:0]  wr_addr;
  chan_t            wr;
  unit_out_t        ures;

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;
  assign out_load   = held_valid && out_free && ((state == ST_PUSH) || (state == ST_FLUSH));
  assign last_idx   = (idx == CH_W'(CHANNELS - 1));
  assign setup_ok   = (int'(item.channel) < CHANNELS);
  assign query_ok   = (int'(ch_q) < CHANNELS);

  assign rd_addr = (state == ST_QUERY) ? CH_W'(ch_q) : idx;
  assign wr_en   = (accept && (item.mode == MODE_SETUP) && setup_ok) || (state == ST_CHECK);
  assign wr_addr = (state == ST_CHECK) ? idx : CH_W'(item.channel);

  always_comb begin
    if (state == ST_CHECK) begin
      wr = ures.wb;
    end else begin
      wr        = '0;
      wr.rem    = item.duration;
      wr.period = item.period;
      wr.duty   = item.duty;
    end
  end

  mtspwm_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  mtspwm_unit u_unit (
    .clk  (clk),
    .load (state == ST_LOAD),
    .cur  (rd),
    .res  (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ch_q <= item.channel;
            case (item.mode)
              MODE_TICK: begin
                idx   <= '0;
                state <= ST_LOAD;
              end
              MODE_QUERY: begin
                state <= ST_QUERY;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_QUERY: begin
          held_valid  <= 1'b1;
          held_ch     <= ch_q;
          held_code   <= EV_QUERY;
          held_active <= query_ok && ((rd.rem != '0) || (rd.period != '0));
          state       <= ST_FLUSH;
        end
        ST_LOAD: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (ures.evt) begin
            ev_code <= ures.code;
            state   <= ST_PUSH;
          end else if (last_idx) begin
            state <= ST_FLUSH;
          end else begin
            idx   <= idx + CH_W'(1);
            state <= ST_LOAD;
          end
        end
        ST_PUSH: begin
          if (!held_valid || out_free) begin
            // release the earlier event, hold this one until the next is known
            if (held_valid) begin
              out_valid  <= 1'b1;
              out_ch     <= held_ch;
              out_code   <= held_code;
              out_active <= held_active;
              out_last   <= 1'b0;
            end
            held_valid  <= 1'b1;
            held_ch     <= CHF_W'(idx);
            held_code   <= ev_code;
            held_active <= 1'b0;
            if (last_idx) begin
              state <= ST_FLUSH;
            end else begin
              idx   <= idx + CH_W'(1);
              state <= ST_LOAD;
            end
          end
        end
        ST_FLUSH: begin
          if (!held_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_ch     <= held_ch;
            out_code   <= held_code;
            out_active <= held_active;
            out_last   <= 1'b1;
            held_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.channel_res = out_ch;
  assign result.event_res   = out_code;
  assign result.active      = out_active;
  assign result.last        = out_last;

  `MTSPWM_ASSERT_SAME(a_idle_no_held, clk, rst,
    state == ST_IDLE, !held_valid, "held result left in idle")
  `MTSPWM_ASSERT_SAME(a_query_last, clk, rst,
    out_valid && (out_code == EV_QUERY), out_last, "query answer not last")
  `MTSPWM_ASSERT_NEXT(a_tick_start, clk, rst,
    accept && (item.mode == MODE_TICK), (state == ST_LOAD) && (idx == '0),
    "tick did not start at channel zero")

endmodule

`default_nettype wire

/* tb/tb_multichannel_timed_strobe_pwm.sv */
// ----------------------------------------------------------------------------
// Multichannel timed strobe PWM testbench
// Drives tick, setup, query and spare-mode transactions through the item
// channel, first from a directed table and then at random, and checks every
// result against a table answer or a cycle-free model of the channel counters.
// Both channels idle and stall at random; one long receiver hold-off fills
// the block, and the sender drains the block at points along the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multichannel_timed_strobe_pwm;
  import mtspwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam mode_t       MODE_SPARE     = 2'd3;
  localparam int          N_DIRECTED     = 25;
  localparam int          RANDOM_ITEMS   = 340;
  localparam int          HOLD_AT        = 60;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    mode_t              mode;
    logic [CHF_W-1:0]   channel;
    logic [DUR_W-1:0]   duration;
    logic [PER_W-1:0]   period;
    logic [DUTY_W-1:0]  duty;
  } strobe_cmd_t;

  typedef struct packed {
    logic [CHF_W-1:0] channel;
    ev_code_t         code;
    logic             active;
    logic             last;
  } strobe_evt_t;

  typedef struct packed {
    strobe_cmd_t cmd;
    logic        typed;
    logic        answer;
  } directed_row_t;

  typedef enum int {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_style_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    {MODE_QUERY, 2'd0, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0},
    {MODE_QUERY, 2'd3, 16'hffff, 16'hffff, 8'hff, 1'b1, 1'b0},
    {MODE_SPARE, 2'd3, 16'hffff, 16'hffff, 8'hff, 1'b1, 1'b0},
    {MODE_SETUP, 2'd0, 16'd1,    16'd1,    8'd0,   1'b1, 1'b0},
    {MODE_SETUP, 2'd1, 16'd0,    16'd1,    8'd50,  1'b1, 1'b0},
    {MODE_SETUP, 2'd2, 16'd3,    16'd4,    8'd50,  1'b1, 1'b0},
    {MODE_SETUP, 2'd3, 16'd0,    16'd3,    8'd255, 1'b1, 1'b0},
    {MODE_QUERY, 2'd0, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1},
    {MODE_TICK,  2'd0, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    {MODE_TICK,  2'd3, 16'hffff, 16'hffff, 8'hff, 1'b0, 1'b0},
    {MODE_TICK,  2'd1, 16'h5a5a, 16'ha5a5, 8'h5a, 1'b0, 1'b0},
    {MODE_TICK,  2'd2, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    {MODE_QUERY, 2'd0, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0},
    {MODE_QUERY, 2'd2, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0},
    {MODE_QUERY, 2'd3, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1},
    {MODE_SETUP, 2'd0, 16'hffff, 16'hffff, 8'd100, 1'b1, 1'b0},
    {MODE_SETUP, 2'd1, 16'd0,    16'd0,    8'd0,   1'b1, 1'b0},
    {MODE_QUERY, 2'd1, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0},
    {MODE_SETUP, 2'd2, 16'd2,    16'd0,    8'd255, 1'b1, 1'b0},
    {MODE_TICK,  2'd0, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    {MODE_TICK,  2'd0, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    {MODE_QUERY, 2'd2, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    {MODE_SETUP, 2'd3, 16'hffff, 16'd2,    8'd50,  1'b1, 1'b0},
    {MODE_TICK,  2'd0, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    {MODE_QUERY, 2'd3, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;

  mtspwm_item_if   item_ch ();
  mtspwm_result_if res_ch ();

  multichannel_timed_strobe_pwm u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  logic [DUR_W-1:0]  remaining  [CHANNELS_DEF] = '{default: '0};
  logic [PER_W-1:0]  period_len [CHANNELS_DEF] = '{default: '0};
  logic [DUTY_W-1:0] duty_pct   [CHANNELS_DEF] = '{default: '0};
  logic [PH_W-1:0]   phase      [CHANNELS_DEF] = '{default: '0};

  strobe_evt_t pending_events [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int unsigned burst_left  = 0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the channel counters by one transaction and queue its results.
  function automatic void strobe_step(input strobe_cmd_t c, input bit emit);
    strobe_evt_t held;
    bit          have;
    bit          fired;
    ev_code_t    code;
    logic [31:0] plen;
    logic [31:0] pulse;
    logic [31:0] nph;
    int          i;
    held = '0;
    have = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        for (i = 0; i < CHANNELS_DEF; i++) begin
          fired = 1'b0;
          code  = EV_TOGGLE;
          if (remaining[i] != '0) begin
            remaining[i] = remaining[i] - DUR_W'(1);
            if (remaining[i] == '0) begin
              phase[i]      = '0;
              period_len[i] = '0;
              fired         = 1'b1;
              code          = EV_COMPLETE;
            end
          end
          if (!fired && period_len[i] != '0) begin
            plen     = 32'(period_len[i]);
            pulse    = plen * 32'(duty_pct[i]) / 32'(PCT);
            nph      = (32'(phase[i]) + 32'd1) % plen;
            phase[i] = nph[PH_W-1:0];
            fired    = (nph == '0) || (nph == pulse);
          end
          if (fired) begin
            if (have && emit) pending_events.push_back(held);
            held = '{i[CHF_W-1:0], code, 1'b0, 1'b0};
            have = 1'b1;
          end
        end
      end
      MODE_SETUP: begin
        if (int'(c.channel) < CHANNELS_DEF) begin
          remaining[c.channel]  = c.duration;
          period_len[c.channel] = c.period;
          duty_pct[c.channel]   = c.duty;
          phase[c.channel]      = '0;
        end
      end
      MODE_QUERY: begin
        held = '{c.channel, EV_QUERY, 1'b0, 1'b0};
        if (int'(c.channel) < CHANNELS_DEF)
          held.active = (remaining[c.channel] != '0) || (period_len[c.channel] != '0);
        have = 1'b1;
      end
      default: begin
      end
    endcase
    if (have && emit) begin
      held.last = 1'b1;
      pending_events.push_back(held);
    end
  endfunction

  function automatic strobe_cmd_t random_cmd();
    strobe_cmd_t c;
    int unsigned pick;
    int unsigned sel;
    c.channel  = CHF_W'($urandom_range(0, CHANNELS_DEF - 1));
    c.duration = DUR_W'($urandom);
    c.period   = PER_W'($urandom);
    c.duty     = DUTY_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      c.mode = MODE_SPARE;
    end else if (pick < 30) begin
      c.mode = MODE_SETUP;
      sel = $urandom_range(0, 9);
      if (sel < 2) c.duration = '0;
      else if (sel < 9) c.duration = DUR_W'($urandom_range(1, 24));
      sel = $urandom_range(0, 9);
      if (sel == 0) c.period = '0;
      else if (sel < 9) c.period = PER_W'($urandom_range(1, 12));
      if ($urandom_range(0, 3) != 0) c.duty = DUTY_W'($urandom_range(0, PCT));
    end else if (pick < 48) begin
      c.mode = MODE_QUERY;
    end else begin
      c.mode = MODE_TICK;
    end
    return c;
  endfunction

  // Offer one transaction, hold it until accepted, then predict.
  task automatic push_cmd(input strobe_cmd_t c, input bit typed, input bit answer);
    item_ch.valid    <= 1'b1;
    item_ch.mode     <= c.mode;
    item_ch.channel  <= c.channel;
    item_ch.duration <= c.duration;
    item_ch.period   <= c.period;
    item_ch.duty     <= c.duty;
    do @(posedge clk); while (!item_ch.ready);
    strobe_step(c, !typed);
    if (typed && c.mode == MODE_QUERY)
      pending_events.push_back('{c.channel, EV_QUERY, answer, 1'b1});
  endtask

  // Drop valid between bursts; on a drain, wait for every result.
  task automatic pace(input bit drain);
    int unsigned gap;
    gap = 0;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
    end
    if (gap > 0 || drain) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) do @(posedge clk); while (pending_events.size() != 0);
    end
  endtask

  initial begin : stimulus
    strobe_cmd_t cmd;
    int          r;
    int          counted;
    rst              <= 1'b1;
    item_ch.valid    <= 1'b0;
    item_ch.mode     <= MODE_TICK;
    item_ch.channel  <= '0;
    item_ch.duration <= '0;
    item_ch.period   <= '0;
    item_ch.duty     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 16);

    for (r = 0; r < N_DIRECTED; r++) begin
      push_cmd(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].answer);
      pace(r == N_DIRECTED - 1);
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      cmd = random_cmd();
      push_cmd(cmd, 1'b0, 1'b0);
      if (cmd.mode != MODE_SPARE) counted++;
      if (counted == HOLD_AT) hold_req = 1'b1;
      pace(cmd.mode != MODE_SPARE &&
           (counted == RANDOM_ITEMS / 2 || counted == RANDOM_ITEMS));
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tb_multichannel_timed_strobe_pwm passed");
    end else begin
      $display("tb_multichannel_timed_strobe_pwm failed");
    end
    $finish;
  end

  initial begin : result_sink
    sink_style_t style;
    int unsigned span;
    int unsigned k;
    res_ch.ready <= 1'b0;
    forever begin
      style = sink_style_t'($urandom_range(0, 2));
      span  = $urandom_range(16, 96);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          res_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (style)
          SINK_FREE:   res_ch.ready <= 1'b1;
          SINK_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default:     res_ch.ready <= (k % 6 < 3);
        endcase
      end
    end
  end

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    strobe_evt_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display({"%0t: unexpected result, expected none, actual channel_res %0d",
                  " event_res %0d active %0d last %0d"},
                 $time, res_ch.channel_res, res_ch.event_res, res_ch.active, res_ch.last);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("channel_res", want.channel, res_ch.channel_res);
        check_field("event_res", want.code, res_ch.event_res);
        check_field("active", want.active, res_ch.active);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_multichannel_timed_strobe_pwm failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/mtspwm_pkg.sv
hdl/mtspwm_ifs.sv
hdl/mtspwm_bank.sv
hdl/mtspwm_unit.sv
hdl/multichannel_timed_strobe_pwm.sv
tb/tb_multichannel_timed_strobe_pwm.sv
